[rtl/core/itdt_pkg.sv]
// shared types, constants and the power-of-ten table for the decimal text writer
package itdt_pkg;

	// power-of-ten table, largest first
	localparam int NUM_POW = 10;
	localparam int POW_W   = 34;
	localparam int IDX_W   = 4;

	// character counts fit the 7-bit width field
	localparam int CNT_W = 7;

	// descriptor queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// character codes
	localparam logic [6:0] CH_NUL   = 7'h00;
	localparam logic [6:0] CH_MINUS = 7'h2D;
	localparam logic [6:0] CH_ZERO  = 7'h30;
	localparam logic [6:0] CH_NINE  = 7'h39;

	// classified item, ready for the back end
	typedef struct packed {
		logic [31:0]      mag;
		logic             neg;
		logic [IDX_W-1:0] first;
		logic [CNT_W-1:0] pad_front;
		logic [IDX_W-1:0] kept;
		logic [CNT_W-1:0] pad_back;
		logic [31:0]      addr;
		logic             wide;
	} itdt_desc_t;

	// 10^(9-idx), meaningless indexes give 1
	function automatic logic [POW_W-1:0] pow10(input logic [IDX_W-1:0] idx);
		logic [POW_W-1:0] p;
		unique case (idx)
			4'd0: p = 34'd1000000000;
			4'd1: p = 34'd100000000;
			4'd2: p = 34'd10000000;
			4'd3: p = 34'd1000000;
			4'd4: p = 34'd100000;
			4'd5: p = 34'd10000;
			4'd6: p = 34'd1000;
			4'd7: p = 34'd100;
			4'd8: p = 34'd10;
			default: p = 34'd1;
		endcase
		return p;
	endfunction

endpackage

[rtl/core/itdt_in_if.sv]
// input channel: value, width, destination address and character size
interface itdt_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] value;
	logic signed [6:0]  width;
	logic [31:0]        dest_address;
	logic               wide_chars;

	modport source (output valid, value, width, dest_address, wide_chars, input ready);
	modport sink (input valid, value, width, dest_address, wide_chars, output ready);
endinterface

[rtl/core/itdt_out_if.sv]
// output channel: one character with its store address
interface itdt_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] store_address;
	logic [6:0]  char_code;
	logic        is_last;

	modport source (output valid, store_address, char_code, is_last, input ready);
	modport sink (input valid, store_address, char_code, is_last, output ready);
endinterface

[rtl/core/itdt_front.sv]
// front end: accepts an item and classifies it into a character plan
module itdt_front #(
	parameter int MAX_WIDTH = 32
) (
	itdt_in_if.sink                  item,
	output logic                     push_valid,
	output itdt_pkg::itdt_desc_t     push_desc,
	input  logic                     push_ready
);

	logic [31:0]                    mag;
	logic                           neg;
	logic                           is_zero;
	logic signed [6:0]              lim;
	logic signed [6:0]              wc;
	logic [itdt_pkg::CNT_W-1:0]     absw;
	logic [itdt_pkg::IDX_W-1:0]     first;
	logic [itdt_pkg::IDX_W-1:0]     digits;
	logic [itdt_pkg::CNT_W-1:0]     digits_w;

	assign lim = $signed(7'(MAX_WIDTH));

	// sign, magnitude and clamped width
	always_comb begin
		neg     = item.value[31];
		is_zero = (item.value == '0);
		mag     = neg ? 32'($unsigned(-item.value)) : $unsigned(item.value);
		priority if (item.width > lim) begin
			wc = lim;
		end else if (item.width < -lim) begin
			wc = -lim;
		end else begin
			wc = item.width;
		end
		absw = wc[6] ? $unsigned(-wc) : $unsigned(wc);
	end

	// leading digit position: count of powers above the magnitude
	always_comb begin
		first = '0;
		for (int k = 0; k < itdt_pkg::NUM_POW - 1; k++) begin
			if ({2'b00, mag} < itdt_pkg::pow10(itdt_pkg::IDX_W'(k)))
				first = first + 1'b1;
		end
		digits   = itdt_pkg::IDX_W'(itdt_pkg::NUM_POW) - first;
		digits_w = itdt_pkg::CNT_W'(digits);
	end

	// character plan
	always_comb begin
		push_desc.mag   = mag;
		push_desc.first = first;
		push_desc.addr  = item.dest_address;
		push_desc.wide  = item.wide_chars;
		if (is_zero) begin
			push_desc.neg       = 1'b0;
			push_desc.pad_front = (wc == '0) ? itdt_pkg::CNT_W'(1) : absw;
			push_desc.kept      = '0;
			push_desc.pad_back  = '0;
		end else begin
			push_desc.neg       = neg;
			push_desc.pad_front = (!wc[6] && absw > digits_w) ? absw - digits_w : '0;
			push_desc.kept      = (wc[6] && absw < digits_w) ? itdt_pkg::IDX_W'(absw) : digits;
			push_desc.pad_back  = (wc[6] && absw > digits_w) ? absw - digits_w : '0;
		end
	end

	assign push_valid = item.valid;
	assign item.ready = push_ready;

endmodule

[rtl/core/itdt_queue.sv]
// small descriptor queue between front and back
module itdt_queue (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push_valid,
	input  itdt_pkg::itdt_desc_t     push_desc,
	output logic                     push_ready,
	output logic                     pop_valid,
	output itdt_pkg::itdt_desc_t     pop_desc,
	input  logic                     pop_ready
);

	itdt_pkg::itdt_desc_t           mem_q [itdt_pkg::QUEUE_DEPTH];
	logic [itdt_pkg::QPTR_W-1:0]    wr_ptr_q;
	logic [itdt_pkg::QPTR_W-1:0]    rd_ptr_q;
	logic [itdt_pkg::QCNT_W-1:0]    count_q;
	logic                           push;
	logic                           pop;

	assign push_ready = (count_q != itdt_pkg::QCNT_W'(itdt_pkg::QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_desc   = mem_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == itdt_pkg::QPTR_W'(itdt_pkg::QUEUE_DEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == itdt_pkg::QPTR_W'(itdt_pkg::QUEUE_DEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_desc;
	end

endmodule

[rtl/core/itdt_back.sv]
// back end: walks a character plan and emits one character per cycle while text does not stall
module itdt_back (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     pop_valid,
	input  itdt_pkg::itdt_desc_t     pop_desc,
	output logic                     pop_ready,
	itdt_out_if.source               text
);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_SIGN  = 6'b000010,
		ST_PADF  = 6'b000100,
		ST_DIGIT = 6'b001000,
		ST_PADB  = 6'b010000,
		ST_TERM  = 6'b100000
	} itdt_phase_t;

	itdt_phase_t                    state_q;
	logic [31:0]                    rem_q;
	logic [itdt_pkg::IDX_W-1:0]     idx_q;
	logic [itdt_pkg::CNT_W-1:0]     padf_q;
	logic [itdt_pkg::IDX_W-1:0]     kept_q;
	logic [itdt_pkg::CNT_W-1:0]     padb_q;
	logic [31:0]                    addr_q;
	logic                           wide_q;
	logic                           ovalid_q;
	logic [31:0]                    oaddr_q;
	logic [6:0]                     ocode_q;
	logic                           olast_q;

	logic                           emit;
	logic                           load;
	logic [6:0]                     code;
	logic [itdt_pkg::IDX_W-1:0]     dig;
	logic [itdt_pkg::POW_W-1:0]     sub;
	logic [itdt_pkg::POW_W-1:0]     step_v;

	// first phase that still has characters to give
	function automatic itdt_phase_t pick(input logic neg,
		input logic [itdt_pkg::CNT_W-1:0] pf, input logic [itdt_pkg::IDX_W-1:0] kp,
		input logic [itdt_pkg::CNT_W-1:0] pb);
		itdt_phase_t r;
		priority if (neg) begin
			r = ST_SIGN;
		end else if (pf != '0) begin
			r = ST_PADF;
		end else if (kp != '0) begin
			r = ST_DIGIT;
		end else if (pb != '0) begin
			r = ST_PADB;
		end else begin
			r = ST_TERM;
		end
		return r;
	endfunction

	assign pop_ready = (state_q == ST_IDLE);
	assign load      = pop_valid && pop_ready;
	assign emit      = (state_q != ST_IDLE) && (!ovalid_q || text.ready);

	// next digit: largest multiple of the current power that fits
	always_comb begin
		dig = '0;
		sub = '0;
		for (int d = 1; d < 10; d++) begin
			step_v = itdt_pkg::POW_W'(d) * itdt_pkg::pow10(idx_q);
			if ({2'b00, rem_q} >= step_v) begin
				dig = itdt_pkg::IDX_W'(d);
				sub = step_v;
			end
		end
	end

	// character for the current phase
	always_comb begin
		unique case (state_q)
			ST_SIGN:  code = itdt_pkg::CH_MINUS;
			ST_PADF:  code = itdt_pkg::CH_ZERO;
			ST_PADB:  code = itdt_pkg::CH_ZERO;
			ST_DIGIT: code = itdt_pkg::CH_ZERO + 7'(dig);
			default:  code = itdt_pkg::CH_NUL;
		endcase
	end

	// phase sequencer and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			ovalid_q <= 1'b0;
		end else begin
			if (emit)
				ovalid_q <= 1'b1;
			else if (text.ready)
				ovalid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (load)
						state_q <= pick(pop_desc.neg, pop_desc.pad_front, pop_desc.kept,
							pop_desc.pad_back);
				end
				ST_SIGN: begin
					if (emit)
						state_q <= pick(1'b0, padf_q, kept_q, padb_q);
				end
				ST_PADF: begin
					if (emit && padf_q == itdt_pkg::CNT_W'(1))
						state_q <= pick(1'b0, '0, kept_q, padb_q);
				end
				ST_DIGIT: begin
					if (emit && kept_q == itdt_pkg::IDX_W'(1))
						state_q <= pick(1'b0, '0, '0, padb_q);
				end
				ST_PADB: begin
					if (emit && padb_q == itdt_pkg::CNT_W'(1))
						state_q <= ST_TERM;
				end
				ST_TERM: begin
					if (emit)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// working plan, address and output register
	always_ff @(posedge clk) begin
		if (load) begin
			rem_q  <= pop_desc.mag;
			idx_q  <= pop_desc.first;
			padf_q <= pop_desc.pad_front;
			kept_q <= pop_desc.kept;
			padb_q <= pop_desc.pad_back;
			addr_q <= pop_desc.addr;
			wide_q <= pop_desc.wide;
		end
		if (emit) begin
			oaddr_q <= addr_q;
			ocode_q <= code;
			olast_q <= (state_q == ST_TERM);
			addr_q  <= addr_q + (wide_q ? 32'd2 : 32'd1);
			if (state_q == ST_PADF)
				padf_q <= padf_q - 1'b1;
			if (state_q == ST_PADB)
				padb_q <= padb_q - 1'b1;
			if (state_q == ST_DIGIT) begin
				kept_q <= kept_q - 1'b1;
				idx_q  <= idx_q + 1'b1;
				rem_q  <= rem_q - sub[31:0];
			end
		end
	end

	assign text.valid         = ovalid_q;
	assign text.store_address = oaddr_q;
	assign text.char_code     = ocode_q;
	assign text.is_last       = olast_q;

endmodule

[rtl/core/integer_to_decimal_text.sv]
// top level: signed integer to decimal text, one character per transaction
//
//   channel   dir   handshake        payload
//   item      in    valid / ready    value, width, dest_address, wide_chars
//   text      out   valid / ready    store_address, char_code, is_last
//
// an item is loaded from the queue and then gives one character at a time (sign,
// padding, digits, terminator); the back-end sequencer emits one character per
// cycle while text does not stall, and takes no new item until the terminator
// has gone. the front classifies in the accept cycle and a two-entry queue
// lets it take items while the back end works or text stalls.
// reset clears the sequencer, queue pointers and output valid.
module integer_to_decimal_text #(
	parameter int MAX_WIDTH = 32
) (
	input logic          clk,
	input logic          arst_n,
	itdt_in_if.sink      item,
	itdt_out_if.source   text
);

	logic                     push_valid;
	logic                     push_ready;
	itdt_pkg::itdt_desc_t     push_desc;
	logic                     pop_valid;
	logic                     pop_ready;
	itdt_pkg::itdt_desc_t     pop_desc;

	// classification
	itdt_front #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_front (
		.item       (item),
		.push_valid (push_valid),
		.push_desc  (push_desc),
		.push_ready (push_ready)
	);

	// descriptor queue
	itdt_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_desc  (push_desc),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_desc   (pop_desc),
		.pop_ready  (pop_ready)
	);

	// character sequencer
	itdt_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_desc  (pop_desc),
		.pop_ready (pop_ready),
		.text      (text)
	);

	// an accepted item is waiting in the queue on the next cycle
	a_item_queued: assert property (@(posedge clk) disable iff (!arst_n)
		(item.valid && item.ready) |=> pop_valid)
		else $error("accepted item missing from queue");

	// terminator and last mark go together
	a_last_nul: assert property (@(posedge clk) disable iff (!arst_n)
		text.valid |-> (text.is_last == (text.char_code == itdt_pkg::CH_NUL)))
		else $error("last mark does not match terminator");

	// every other character is a digit or a minus sign
	a_char_set: assert property (@(posedge clk) disable iff (!arst_n)
		(text.valid && !text.is_last) |->
			((text.char_code >= itdt_pkg::CH_ZERO && text.char_code <= itdt_pkg::CH_NINE) ||
			 text.char_code == itdt_pkg::CH_MINUS))
		else $error("unexpected character code");

endmodule
